FILE: sv/ansi_escape_stripper_macros.svh
// Assertion macros used by the escape stripper output stage (aes_out).
`ifndef ANSI_ESCAPE_STRIPPER_MACROS_SVH
`define ANSI_ESCAPE_STRIPPER_MACROS_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_CLK(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("assertion failed");
`define AES_ASSERT(label, prop) `AES_ASSERT_CLK(label, clk, rst, prop)
`else
`define AES_ASSERT_CLK(label, clock, reset, prop)
`define AES_ASSERT(label, prop)
`endif
`endif

FILE: sv/aes_pkg.sv
// Shared types and character constants of the escape stripper.
package aes_pkg;

  typedef enum logic [1:0] {
    ST_TEXT  = 2'd0,
    ST_ESC   = 2'd1,
    ST_PARAM = 2'd2,
    ST_INTER = 2'd3
  } parse_state_t;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_NUL      = 8'h00;

  // Request from the parser to the output stage.
  typedef struct packed {
    logic       valid;
    logic       newline;
    logic [7:0] byte_val;
  } aes_req_t;

endpackage

FILE: sv/aes_parse.sv
// Input register and escape sequence parser.
module aes_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             load_ok,
  output aes_pkg::aes_req_t req
);

  logic                  hold_valid;
  logic [7:0]            hold_byte;
  aes_pkg::parse_state_t state;
  aes_pkg::parse_state_t state_next;
  logic                  pass;
  logic                  take;

  always_comb begin
    pass       = 1'b0;
    state_next = state;
    case (state)
      aes_pkg::ST_TEXT: begin
        if (hold_byte == aes_pkg::CH_ESC) begin
          state_next = aes_pkg::ST_ESC;
        end else begin
          pass = 1'b1;
        end
      end
      aes_pkg::ST_ESC: begin
        if (hold_byte == aes_pkg::CH_LBRACKET) begin
          state_next = aes_pkg::ST_PARAM;
        end else begin
          pass       = 1'b1;
          state_next = aes_pkg::ST_TEXT;
        end
      end
      aes_pkg::ST_PARAM: begin
        if (hold_byte inside {[aes_pkg::CH_ZERO:aes_pkg::CH_QUEST]}) begin
          state_next = aes_pkg::ST_PARAM;
        end else if (hold_byte inside {[aes_pkg::CH_SPACE:aes_pkg::CH_SLASH]}) begin
          state_next = aes_pkg::ST_INTER;
        end else if (hold_byte inside {[aes_pkg::CH_AT:aes_pkg::CH_TILDE]}) begin
          state_next = aes_pkg::ST_TEXT;
        end else begin
          pass       = 1'b1;
          state_next = aes_pkg::ST_TEXT;
        end
      end
      default: begin
        if (hold_byte inside {[aes_pkg::CH_SPACE:aes_pkg::CH_SLASH]}) begin
          state_next = aes_pkg::ST_INTER;
        end else if (hold_byte inside {[aes_pkg::CH_AT:aes_pkg::CH_TILDE]}) begin
          state_next = aes_pkg::ST_TEXT;
        end else begin
          pass       = 1'b1;
          state_next = aes_pkg::ST_TEXT;
        end
      end
    endcase
  end

  // dropped bytes retire without the output stage
  assign take         = hold_valid && (!pass || load_ok);
  assign in_ready     = !hold_valid || take;
  assign req.valid    = hold_valid && pass;
  assign req.newline  = (hold_byte == aes_pkg::CH_NEWLINE);
  assign req.byte_val = hold_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      state      <= aes_pkg::ST_TEXT;
    end else begin
      if (take) begin
        state <= state_next;
      end
      if (in_ready) begin
        hold_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= in_byte;
    end
  end

endmodule

FILE: sv/aes_out.sv
// Output register with pending end-of-record terminator.
`include "ansi_escape_stripper_macros.svh"
module aes_out (
  input  logic              clk,
  input  logic              rst,
  input  aes_pkg::aes_req_t req,
  output logic              load_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              end_of_record
);

  logic pend;
  logic send_term;
  logic load;

  assign load_ok   = !out_valid || (out_ready && !pend);
  assign send_term = out_valid && out_ready && pend;
  assign load      = req.valid && load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (send_term) begin
      pend <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      pend      <= req.newline;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send_term) begin
      out_byte      <= aes_pkg::CH_NUL;
      end_of_record <= 1'b1;
    end else if (load) begin
      out_byte      <= req.byte_val;
      end_of_record <= 1'b0;
    end
  end

  `AES_ASSERT(a_pend_valid, pend |-> out_valid && !end_of_record)
  `AES_ASSERT(a_pend_newline, pend |-> out_byte == aes_pkg::CH_NEWLINE)
  `AES_ASSERT(a_term_follows, send_term |=> out_valid && end_of_record && !pend)
  `AES_ASSERT(a_term_zero, out_valid && end_of_record |-> out_byte == aes_pkg::CH_NUL)

endmodule

FILE: sv/ansi_escape_stripper.sv
// A passed byte is on the output in the cycle after the output stage accepts its request.
// Throughput: one input byte per cycle while out_ready is high; a passed newline
// holds the output register until its zero terminator has been sent.
// Escape bytes are dropped in the parser stage and take no output cycle.
// Reset clears both stages and returns the parser to plain text.
module ansi_escape_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       end_of_record
);

  aes_pkg::aes_req_t req;
  logic              load_ok;

  aes_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .load_ok  (load_ok),
    .req      (req)
  );

  aes_out u_out (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .load_ok       (load_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .end_of_record (end_of_record)
  );

endmodule
